// ----- src/adcavg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcavg_pkg
// Shared types and constants of the converter averaging and selection block.
// ----------------------------------------------------------------------------
package adcavg_pkg;

	// sample and result field widths
	localparam int SAMPLE_W = 12;
	localparam int SAMPLE_MAX = 4095;
	localparam int SW_W = 2;

	// defaults of the top level parameters
	localparam int DEF_SAMPLES_PER_SLOT = 16;
	localparam int DEF_OUTPUT_MAX = 4095;

	// rotation of slots
	localparam int SLOT_COUNT = 3;
	localparam logic [1:0] SLOT_INT_POT = 2'd0;
	localparam logic [1:0] SLOT_EXT_POT = 2'd1;
	localparam logic [1:0] SLOT_SENSE = 2'd2;

	// switch state codes
	localparam logic [SW_W-1:0] SW_RELEASED = 2'd0;
	localparam logic [SW_W-1:0] SW_PRESSED = 2'd1;
	localparam logic [SW_W-1:0] SW_NONE = 2'd2;

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_INT_OFFSET = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INT_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INT_DIVISOR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_OFFSET = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_GAIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_DIVISOR = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SENSE_THRESHOLD = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_THRESHOLD = 3'd7;

	localparam int OFFSET_W = 13;
	localparam int GAIN_W = 16;
	localparam int DIVISOR_W = 16;

	typedef struct packed {
		logic [OFFSET_W-1:0]  internal_offset;
		logic [GAIN_W-1:0]    internal_gain;
		logic [DIVISOR_W-1:0] internal_divisor;
		logic [OFFSET_W-1:0]  external_offset;
		logic [GAIN_W-1:0]    external_gain;
		logic [DIVISOR_W-1:0] external_divisor;
		logic [SAMPLE_W-1:0]  sense_threshold;
		logic [SAMPLE_W-1:0]  press_threshold;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		internal_offset:  13'd0,
		internal_gain:    16'd1,
		internal_divisor: 16'd1,
		external_offset:  13'd0,
		external_gain:    16'd1,
		external_divisor: 16'd1,
		sense_threshold:  12'd2048,
		press_threshold:  12'd1024
	};

	// shared divider: product of offset average (13 bit) and gain (16 bit)
	localparam int TERM_W = 13;
	localparam int PROD_W = TERM_W + GAIN_W;
	localparam int DIV_N_W = PROD_W + (PROD_W % 2);
	localparam int DIV_D_W = DIVISOR_W;
	localparam int STEP_W = $clog2(DIV_N_W / 2 + 1);

	typedef struct packed {
		logic               start;
		logic [STEP_W-1:0]  steps;
		logic [DIV_N_W-1:0] dividend;
		logic [DIV_D_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DIV_N_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ----- src/adcavg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcavg_if
// Valid/ready channels for converter samples and for selection results.
// ----------------------------------------------------------------------------
interface adcavg_in_if;
	logic        valid;
	logic        ready;
	logic [11:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface adcavg_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] pot_value;
	logic        pot_valid;
	logic        external_present;
	logic [1:0]  switch_state;

	modport source (output valid, output pot_value, output pot_valid,
		output external_present, output switch_state, input ready);
	modport sink (input valid, input pot_value, input pot_valid,
		input external_present, input switch_state, output ready);
endinterface

// ----- src/adc_channel_average_select_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_channel_average_select_top
// Round-robin converter averaging with pot selection and affine scaling.
// ----------------------------------------------------------------------------
// Usage:
// - sample_ch takes one 12-bit reading per transaction, in the fixed slot
//   order internal pot, external pot, external sense, then round again.
// - result_ch gives one transaction per sample: scaled selected pot value,
//   its valid flag, external unit present and switch state.
// - cfg_we/cfg_index/cfg_data write the eight scaling and threshold
//   registers; write them only while no sample is in flight.
// - The front end takes a sample into a two-entry queue and takes no new
//   one until it has updated the ring and pushed that sample's snapshot.
//   A shared divider that retires two quotient bits a cycle does up to
//   three divisions per sample: sense average, pot average and scaling.
//   An empty sense slot skips the first, an empty pot slot the last two,
//   and a non-positive offset sum skips the scaling division.
// - Reset clears the sums, fill counts, ring position and registers to
//   their defaults; the sample ring itself is not cleared and needs no
//   clearing pass.
// - A stalled result_ch keeps the result in the output register; the back
//   end finishes the next sample meanwhile and the queue then fills up
//   before sample_ch stops taking readings.
// ----------------------------------------------------------------------------
module adc_channel_average_select_top import adcavg_pkg::*; #(
	parameter int SAMPLES_PER_SLOT = DEF_SAMPLES_PER_SLOT,
	parameter int OUTPUT_MAX = DEF_OUTPUT_MAX
) (
	input  logic                  clk,
	input  logic                  arst_n,
	adcavg_in_if.sink             sample_ch,
	adcavg_out_if.source          result_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SUM_W = $clog2(SAMPLES_PER_SLOT * SAMPLE_MAX + 1);
	localparam int FILL_W = $clog2(SAMPLES_PER_SLOT + 1);
	localparam int SNAP_W = SLOT_COUNT * (SUM_W + FILL_W);

	cfg_t              cfg_q;
	logic              push_valid;
	logic              push_ready;
	logic [SNAP_W-1:0] push_data;
	logic              pop_valid;
	logic              pop_ready;
	logic [SNAP_W-1:0] pop_data;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INT_OFFSET:      cfg_q.internal_offset <= cfg_data[OFFSET_W-1:0];
				REG_INT_GAIN:        cfg_q.internal_gain <= cfg_data[GAIN_W-1:0];
				REG_INT_DIVISOR:     cfg_q.internal_divisor <= cfg_data[DIVISOR_W-1:0];
				REG_EXT_OFFSET:      cfg_q.external_offset <= cfg_data[OFFSET_W-1:0];
				REG_EXT_GAIN:        cfg_q.external_gain <= cfg_data[GAIN_W-1:0];
				REG_EXT_DIVISOR:     cfg_q.external_divisor <= cfg_data[DIVISOR_W-1:0];
				REG_SENSE_THRESHOLD: cfg_q.sense_threshold <= cfg_data[SAMPLE_W-1:0];
				REG_PRESS_THRESHOLD: cfg_q.press_threshold <= cfg_data[SAMPLE_W-1:0];
			endcase
		end
	end

	// sample ring and running sums
	adcavg_front #(
		.SAMPLES_PER_SLOT(SAMPLES_PER_SLOT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.smp        (sample_ch),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// snapshot queue
	adcavg_fifo #(
		.WIDTH(SNAP_W)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// evaluation sequencer
	adcavg_back #(
		.SAMPLES_PER_SLOT(SAMPLES_PER_SLOT),
		.OUTPUT_MAX(OUTPUT_MAX)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.res       (result_ch)
	);

	// shared divider
	adcavg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// no switch reading without an external unit
	assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && !result_ch.external_present |-> result_ch.switch_state == SW_NONE)
		else $error("switch state reported without external unit");

	// an empty pot slot gives a zero value
	assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && !result_ch.pot_valid |-> result_ch.pot_value == '0)
		else $error("pot value not zero for empty slot");

	// front end is busy for the cycle after taking a sample
	assert property (@(posedge clk) disable iff (!arst_n)
		sample_ch.valid && sample_ch.ready |=> !sample_ch.ready)
		else $error("sample taken while ring update pending");

	// divider is only started while the queue has delivered a snapshot
	assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !pop_ready)
		else $error("divider started with back end idle");

endmodule

// ----- src/adcavg_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcavg_fifo
// Two-entry queue between the sample front end and the evaluation back end.
// ----------------------------------------------------------------------------
module adcavg_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_data = entry_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ----- src/adcavg_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcavg_front
// Takes samples in slot rotation, keeps the sample ring, running sums and
// fill counts, and queues a snapshot of all three slots per sample.
// ----------------------------------------------------------------------------
module adcavg_front import adcavg_pkg::*; #(
	parameter int SAMPLES_PER_SLOT = DEF_SAMPLES_PER_SLOT,
	localparam int SUM_W = $clog2(SAMPLES_PER_SLOT * SAMPLE_MAX + 1),
	localparam int FILL_W = $clog2(SAMPLES_PER_SLOT + 1),
	localparam int SNAP_W = SLOT_COUNT * (SUM_W + FILL_W)
) (
	input  logic              clk,
	input  logic              arst_n,
	adcavg_in_if.sink         smp,
	output logic              push_valid,
	input  logic              push_ready,
	output logic [SNAP_W-1:0] push_data
);

	localparam int DEPTH = SLOT_COUNT * SAMPLES_PER_SLOT;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef struct packed {
		logic [SUM_W-1:0]  sense_sum;
		logic [FILL_W-1:0] sense_fill;
		logic [SUM_W-1:0]  ext_sum;
		logic [FILL_W-1:0] ext_fill;
		logic [SUM_W-1:0]  int_sum;
		logic [FILL_W-1:0] int_fill;
	} snap_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_UPDATE,
		F_PUSH
	} state_t;

	state_t              state_q;
	logic [SAMPLE_W-1:0] store [DEPTH];
	logic [SAMPLE_W-1:0] old_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [ADDR_W-1:0]   pos_q;
	logic [1:0]          slot_q;
	logic [SUM_W-1:0]    sum_q [SLOT_COUNT];
	logic [FILL_W-1:0]   fill_q [SLOT_COUNT];
	logic                accept;
	logic                ring_full;
	logic [SUM_W-1:0]    sum_base;
	logic [SUM_W-1:0]    sum_next;
	snap_t               snap;

	assign smp.ready = (state_q == F_IDLE);
	assign accept = smp.valid && smp.ready;

	// sample ring: old entry read on accept, new one written in the update state
	always_ff @(posedge clk) begin
		if (accept) begin
			old_q <= store[pos_q];
		end
		if (state_q == F_UPDATE) begin
			store[pos_q] <= sample_q;
		end
	end

	// running sum of the current slot
	always_comb begin
		ring_full = (fill_q[slot_q] >= FILL_W'(SAMPLES_PER_SLOT));
		sum_base = ring_full ? (sum_q[slot_q] - SUM_W'(old_q)) : sum_q[slot_q];
		sum_next = sum_base + SUM_W'(sample_q);
	end

	// snapshot handed to the back end
	always_comb begin
		snap.sense_sum = sum_q[SLOT_SENSE];
		snap.sense_fill = fill_q[SLOT_SENSE];
		snap.ext_sum = sum_q[SLOT_EXT_POT];
		snap.ext_fill = fill_q[SLOT_EXT_POT];
		snap.int_sum = sum_q[SLOT_INT_POT];
		snap.int_fill = fill_q[SLOT_INT_POT];
	end

	assign push_data = snap;
	assign push_valid = (state_q == F_PUSH);

	// control and slot bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			pos_q <= '0;
			slot_q <= SLOT_INT_POT;
			sample_q <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				sum_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						sample_q <= smp.sample;
						state_q <= F_UPDATE;
					end
				end
				F_UPDATE: begin
					sum_q[slot_q] <= sum_next;
					if (!ring_full) begin
						fill_q[slot_q] <= fill_q[slot_q] + FILL_W'(1);
					end
					pos_q <= (pos_q == ADDR_W'(DEPTH - 1)) ? '0 : pos_q + ADDR_W'(1);
					slot_q <= (slot_q == SLOT_SENSE) ? SLOT_INT_POT : slot_q + 2'd1;
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/adcavg_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcavg_div
// Shared unsigned restoring divider, two quotient bits per cycle. The
// dividend comes aligned to the top; steps gives the number of bit pairs.
// ----------------------------------------------------------------------------
module adcavg_div import adcavg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_N_W-1:0] work_q;
	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_D_W-1:0] den_q;
	logic [STEP_W-1:0]  count_q;
	logic               busy_q;
	logic               done_q;
	logic [DIV_N_W-1:0] work_n;
	logic [DIV_D_W-1:0] rem_n;

	// two compare and subtract steps
	always_comb begin
		logic [DIV_D_W:0] part;
		work_n = work_q;
		rem_n = rem_q;
		for (int k = 0; k < 2; k++) begin
			part = {rem_n, work_n[DIV_N_W-1]};
			work_n = {work_n[DIV_N_W-2:0], 1'b0};
			if (part >= {1'b0, den_q}) begin
				part = part - {1'b0, den_q};
				work_n[0] = 1'b1;
			end
			rem_n = part[DIV_D_W-1:0];
		end
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_q <= '0;
			rem_q <= '0;
			den_q <= '0;
			count_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				work_q <= req.dividend;
				rem_q <= '0;
				den_q <= req.divisor;
				count_q <= req.steps;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				work_q <= work_n;
				rem_q <= rem_n;
				count_q <= count_q - STEP_W'(1);
				if (count_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = work_q;

endmodule

// ----- src/adcavg_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcavg_back
// Evaluates one snapshot: sense average, unit presence and switch state,
// selected pot average, offset, gain and divisor, clamp; holds the result.
// ----------------------------------------------------------------------------
module adcavg_back import adcavg_pkg::*; #(
	parameter int SAMPLES_PER_SLOT = DEF_SAMPLES_PER_SLOT,
	parameter int OUTPUT_MAX = DEF_OUTPUT_MAX,
	localparam int SUM_W = $clog2(SAMPLES_PER_SLOT * SAMPLE_MAX + 1),
	localparam int FILL_W = $clog2(SAMPLES_PER_SLOT + 1),
	localparam int SNAP_W = SLOT_COUNT * (SUM_W + FILL_W)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  logic [SNAP_W-1:0] pop_data,
	output div_req_t          div_req,
	input  div_rsp_t          div_rsp,
	adcavg_out_if.source      res
);

	localparam int SUM_EW = SUM_W + (SUM_W % 2);
	localparam logic [DIV_N_W-1:0] OUT_MAX_V = DIV_N_W'(OUTPUT_MAX);

	typedef struct packed {
		logic [SUM_W-1:0]  sense_sum;
		logic [FILL_W-1:0] sense_fill;
		logic [SUM_W-1:0]  ext_sum;
		logic [FILL_W-1:0] ext_fill;
		logic [SUM_W-1:0]  int_sum;
		logic [FILL_W-1:0] int_fill;
	} snap_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_SENSE,
		B_SENSE_WAIT,
		B_POT,
		B_POT_WAIT,
		B_MUL,
		B_SCALE_WAIT,
		B_FINISH
	} state_t;

	state_t              state_q;
	snap_t               snap_q;
	div_req_t            req_q;
	logic                present_q;
	logic [SW_W-1:0]     switch_q;
	logic                pot_ok_q;
	logic [SAMPLE_W-1:0] value_q;
	logic [TERM_W-1:0]   term_q;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] out_value_q;
	logic                out_pot_ok_q;
	logic                out_present_q;
	logic [SW_W-1:0]     out_switch_q;

	logic [SAMPLE_W-1:0]  avg;
	logic [SUM_W-1:0]     pot_sum;
	logic [FILL_W-1:0]    pot_fill;
	logic [OFFSET_W-1:0]  pot_offset;
	logic [GAIN_W-1:0]    pot_gain;
	logic [DIVISOR_W-1:0] pot_divisor;
	logic [TERM_W:0]      term;
	logic [PROD_W-1:0]    product;
	logic                 out_free;

	// selected pot slot and its scaling registers
	always_comb begin
		avg = div_rsp.quotient[SAMPLE_W-1:0];
		if (present_q) begin
			pot_sum = snap_q.ext_sum;
			pot_fill = snap_q.ext_fill;
			pot_offset = cfg.external_offset;
			pot_gain = cfg.external_gain;
			pot_divisor = cfg.external_divisor;
		end else begin
			pot_sum = snap_q.int_sum;
			pot_fill = snap_q.int_fill;
			pot_offset = cfg.internal_offset;
			pot_gain = cfg.internal_gain;
			pot_divisor = cfg.internal_divisor;
		end
		// average plus signed offset, 14 bit two's complement
		term = {2'b00, avg} + {pot_offset[OFFSET_W-1], pot_offset};
		product = PROD_W'(term_q) * PROD_W'(pot_gain);
	end

	assign pop_ready = (state_q == B_IDLE);
	assign out_free = !out_valid_q || res.ready;
	assign div_req = req_q;

	// sequencer around the shared divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			snap_q <= '0;
			req_q <= '0;
			present_q <= 1'b0;
			switch_q <= SW_NONE;
			pot_ok_q <= 1'b0;
			value_q <= '0;
			term_q <= '0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_pot_ok_q <= 1'b0;
			out_present_q <= 1'b0;
			out_switch_q <= SW_NONE;
		end else begin
			req_q.start <= 1'b0;
			if (out_valid_q && res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop_valid) begin
						snap_q <= pop_data;
						state_q <= B_SENSE;
					end
				end
				B_SENSE: begin
					if (snap_q.sense_fill == '0) begin
						present_q <= 1'b0;
						switch_q <= SW_NONE;
						state_q <= B_POT;
					end else begin
						req_q.start <= 1'b1;
						req_q.steps <= STEP_W'(SUM_EW / 2);
						req_q.dividend <= {SUM_EW'(snap_q.sense_sum), {(DIV_N_W - SUM_EW){1'b0}}};
						req_q.divisor <= DIV_D_W'(snap_q.sense_fill);
						state_q <= B_SENSE_WAIT;
					end
				end
				B_SENSE_WAIT: begin
					if (div_rsp.done) begin
						if (avg <= cfg.sense_threshold) begin
							present_q <= 1'b1;
							switch_q <= (avg <= cfg.press_threshold) ? SW_PRESSED : SW_RELEASED;
						end else begin
							present_q <= 1'b0;
							switch_q <= SW_NONE;
						end
						state_q <= B_POT;
					end
				end
				B_POT: begin
					if (pot_fill == '0) begin
						pot_ok_q <= 1'b0;
						value_q <= '0;
						state_q <= B_FINISH;
					end else begin
						pot_ok_q <= 1'b1;
						req_q.start <= 1'b1;
						req_q.steps <= STEP_W'(SUM_EW / 2);
						req_q.dividend <= {SUM_EW'(pot_sum), {(DIV_N_W - SUM_EW){1'b0}}};
						req_q.divisor <= DIV_D_W'(pot_fill);
						state_q <= B_POT_WAIT;
					end
				end
				B_POT_WAIT: begin
					if (div_rsp.done) begin
						// zero or negative sum truncates to zero
						if (term[TERM_W] || term == '0) begin
							value_q <= '0;
							state_q <= B_FINISH;
						end else begin
							term_q <= term[TERM_W-1:0];
							state_q <= B_MUL;
						end
					end
				end
				B_MUL: begin
					req_q.start <= 1'b1;
					req_q.steps <= STEP_W'(DIV_N_W / 2);
					req_q.dividend <= DIV_N_W'(product);
					req_q.divisor <= (pot_divisor == '0) ? DIV_D_W'(1) : pot_divisor;
					state_q <= B_SCALE_WAIT;
				end
				B_SCALE_WAIT: begin
					if (div_rsp.done) begin
						if (div_rsp.quotient > OUT_MAX_V) begin
							value_q <= OUT_MAX_V[SAMPLE_W-1:0];
						end else begin
							value_q <= div_rsp.quotient[SAMPLE_W-1:0];
						end
						state_q <= B_FINISH;
					end
				end
				B_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_value_q <= value_q;
						out_pot_ok_q <= pot_ok_q;
						out_present_q <= present_q;
						out_switch_q <= switch_q;
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign res.valid = out_valid_q;
	assign res.pot_value = out_value_q;
	assign res.pot_valid = out_pot_ok_q;
	assign res.external_present = out_present_q;
	assign res.switch_state = out_switch_q;

endmodule
